@@ hw/rtl/aes_pkg.sv @@
`timescale 1ns / 1ps

package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   valid;
    block_t state;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; default: r = 8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block sits in bits [127-8k -: 8].
  function automatic logic [7:0] get_byte(input block_t s, input int k);
    return s[BlockW-1-8*k -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4 * ((c + r) % 4)));
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4 * c);
      a1 = get_byte(s, 4 * c + 1);
      a2 = get_byte(s, 4 * c + 2);
      a3 = get_byte(s, 4 * c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-32*c -: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      t[BlockW-9-32*c -: 8]    = a1 ^ al ^ xtime(a1 ^ a2);
      t[BlockW-17-32*c -: 8]   = a2 ^ al ^ xtime(a2 ^ a3);
      t[BlockW-25-32*c -: 8]   = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Next round key from the previous one.
  function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
    block_t n;
    logic [31:0] w;
    w = {sbox(k[23:16]) ^ rcon, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    n[127:96] = k[127:96] ^ w;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    return n;
  endfunction

  function automatic logic [7:0] rcon_of(input int round);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 1; i < round; i++) r = xtime(r);
    return r;
  endfunction

endpackage

@@ hw/rtl/aes_if.sv @@
`timescale 1ns / 1ps

interface aes_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, data_high, data_low, input ready);
  modport sink (input valid, data_high, data_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

@@ hw/rtl/aes128_block_encrypt.sv @@
`timescale 1ns / 1ps

// Channel   Role   Payload
// in_blk    sink   plaintext high/low, 64 bits each
// out_blk   source ciphertext high/low, 64 bits each
// cfg       sink   index 0 key_high, index 1 key_low; always ready
//
// The pipeline has eleven register stages: the initial key addition and one
// stage per round. Each round stage holds one S-box layer for the state and
// one for the round key, which is expanded alongside the block. One block per
// cycle is sustained while the output is not stalled.
// Reset clears the valid bits and sets the key to zero.
// A stall at the output freezes the whole pipeline; nothing is lost.
module aes128_block_encrypt (
  input  logic clk_i,
  input  logic rst_ni,
  aes_blk_if.sink   in_blk,
  aes_blk_if.source out_blk,
  aes_cfg_if.sink   cfg
);

  localparam int unsigned N = aes_pkg::NumRounds;

  logic [63:0] key_high_q, key_low_q;
  logic en;

  logic            stg0_valid_q;
  aes_pkg::block_t stg0_state_q;
  aes_pkg::block_t key0_q;

  aes_pkg::stage_t stg [N+1];
  aes_pkg::block_t key [N+1];

  // The pipeline advances unless the last stage holds a beat not taken.
  assign en = !stg[N].valid || out_blk.ready;
  assign in_blk.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == aes_pkg::RegKeyHigh) begin
        key_high_q <= cfg.wdata;
      end else if (cfg.index == aes_pkg::RegKeyLow) begin
        key_low_q <= cfg.wdata;
      end
    end
  end

  // Stage zero: initial AddRoundKey; the key is captured with the block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg0_valid_q <= 1'b0;
    end else if (en) begin
      stg0_valid_q <= in_blk.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg0_state_q <= {in_blk.data_high, in_blk.data_low} ^ {key_high_q, key_low_q};
      key0_q <= {key_high_q, key_low_q};
    end
  end

  assign stg[0] = '{valid: stg0_valid_q, state: stg0_state_q};
  assign key[0] = key0_q;

  for (genvar r = 1; r <= N; r++) begin : g_round
    aes_round #(.Round(r)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (stg[r-1]),
      .key_i   (key[r-1]),
      .stage_o (stg[r]),
      .key_o   (key[r])
    );
  end

  assign out_blk.valid = stg[N].valid;
  assign out_blk.data_high = stg[N].state[127:64];
  assign out_blk.data_low = stg[N].state[63:0];

`ifndef NO_ASSERTIONS
  // A held output beat must stay valid, with its high half unchanged, while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_blk.valid && !out_blk.ready |=> out_blk.valid && $stable(out_blk.data_high))
    else $error("output changed under stall");
  // Input is refused exactly while the last stage is stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_blk.ready == !(out_blk.valid && !out_blk.ready))
    else $error("ready mismatch");
  // An accepted beat reaches stage zero.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_blk.valid && in_blk.ready |=> stg[0].valid)
    else $error("beat lost at entry");
`endif

endmodule

@@ hw/rtl/aes_round.sv @@
`timescale 1ns / 1ps

// One cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// The round key travels with the data and is advanced here as well.
module aes_round #(
  parameter int unsigned Round = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  aes_pkg::stage_t     stage_i,
  input  aes_pkg::block_t     key_i,
  output aes_pkg::stage_t     stage_o,
  output aes_pkg::block_t     key_o
);

  aes_pkg::block_t key_d, state_d, sh;
  aes_pkg::block_t key_q, state_q;
  logic valid_q;

  always_comb begin
    key_d = aes_pkg::next_key(key_i, aes_pkg::rcon_of(Round));
    sh = aes_pkg::sub_shift(stage_i.state);
    if (Round < aes_pkg::NumRounds) begin
      sh = aes_pkg::mix_columns(sh);
    end
    state_d = sh ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q <= key_d;
    end
  end

  assign stage_o = '{valid: valid_q, state: state_q};
  assign key_o = key_q;

endmodule

@@ tb/sv/tb_aes128_block_encrypt.sv @@
`timescale 1ns / 1ps

// Testbench for the pipelined AES-128 block encryptor.
module tb_aes128_block_encrypt;

  localparam int unsigned PipeDepth = 11;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aes_blk_if in_blk ();
  aes_blk_if out_blk ();
  aes_cfg_if cfg ();

  aes128_block_encrypt dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_blk (in_blk),
    .out_blk(out_blk),
    .cfg    (cfg)
  );

  always #4 clk_i = ~clk_i;

  // Our own view of the key registers; the model follows every accepted write.
  logic [63:0] key_hi_shadow;
  logic [63:0] key_lo_shadow;

  // Expected ciphertexts, oldest first.
  aes_pkg::block_t cipher_queue[$];
  int unsigned error_count;
  int unsigned blocks_sent;
  int unsigned blocks_checked;
  int unsigned cycle_count;
  int unsigned key_writes;

  // Idle controls: a percentage of cycles on which a side holds off.
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // The S-box is built from scratch here from GF(2^8) inverses and the
  // affine map, so the prediction shares no table with the RTL.
  logic [7:0] subst_table[256];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic build_subst_table();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      s = 8'h63;
      for (int i = 0; i < 8; i++) begin
        s[i] = s[i] ^ inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8]
               ^ inv[(i + 6) % 8] ^ inv[(i + 7) % 8];
      end
      subst_table[x] = s;
    end
  endtask

  // Full AES-128 encryption of one block, byte 0 in the top bits.
  function automatic aes_pkg::block_t encrypt_block(input logic [63:0] k_hi,
                                                    input logic [63:0] k_lo,
                                                    input aes_pkg::block_t pt);
    logic [7:0] sched[176];
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [7:0] w[4];
    logic [7:0] first;
    logic [7:0] rc;
    logic [7:0] a0, a1, a2, a3, al;
    aes_pkg::block_t kb;
    aes_pkg::block_t res;
    kb = {k_hi, k_lo};
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      sched[i] = kb[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ sched[i];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = sched[4*(i-1)+j];
      if (i % 4 == 0) begin
        first = w[0];
        w[0] = subst_table[w[1]] ^ rc;
        w[1] = subst_table[w[2]];
        w[2] = subst_table[w[3]];
        w[3] = subst_table[first];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) sched[4*i+j] = sched[4*(i-4)+j] ^ w[j];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) tmp[r+4*c] = subst_table[st[r+4*((c+r)%4)]];
      end
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          tmp[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          tmp[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          tmp[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ sched[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  // Presents one key register write and records it once the beat is taken.
  // The caller drops valid after its last write.
  task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= value;
    do @(posedge clk_i); while (!cfg.ready);
    if (idx == aes_pkg::RegKeyHigh) key_hi_shadow = value;
    else key_lo_shadow = value;
    key_writes++;
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    write_key(aes_pkg::RegKeyHigh, hi);
    write_key(aes_pkg::RegKeyLow, lo);
    cfg.valid <= 1'b0;
  endtask

  // Sends one plaintext beat, with a random hold-off before it. The expected
  // ciphertext is queued when the beat is accepted.
  task automatic send_block(input aes_pkg::block_t pt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_blk.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_blk.valid     <= 1'b1;
    in_blk.data_high <= pt[127:64];
    in_blk.data_low  <= pt[63:0];
    do @(posedge clk_i); while (!in_blk.ready);
    cipher_queue.push_back(encrypt_block(key_hi_shadow, key_lo_shadow, pt));
    blocks_sent++;
  endtask

  task automatic end_burst();
    in_blk.valid <= 1'b0;
  endtask

  // Waits until every ciphertext has come back, then lets the pipe drain.
  task automatic drain();
    end_burst();
    while (cipher_queue.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic aes_pkg::block_t rand_block();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Output side: random stalls, and a check of each accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_blk.valid && out_blk.ready) begin
        if (cipher_queue.size() == 0) begin
          report_mismatch("ciphertext beat with nothing expected", out_blk.data_high,
                          64'h0);
        end else begin
          aes_pkg::block_t want;
          want = cipher_queue.pop_front();
          if (out_blk.data_high !== want[127:64])
            report_mismatch("ciphertext_high", out_blk.data_high, want[127:64]);
          if (out_blk.data_low !== want[63:0])
            report_mismatch("ciphertext_low", out_blk.data_low, want[63:0]);
          blocks_checked++;
        end
      end
      out_blk.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // The standard vector with the reset (all-zero) key, then the FIPS-197
  // appendix vector, then field extremes under extreme keys.
  task automatic test_directed();
    send_block('0);
    send_block('1);
    drain();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(128'h00112233445566778899aabbccddeeff);
    send_block('0);
    send_block('1);
    send_block({64'h8000000000000000, 64'h0000000000000001});
    drain();
    load_key('1, '1);
    send_block('0);
    send_block('1);
    send_block(128'h55555555555555555555555555555555);
    send_block(128'haaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa);
    drain();
    load_key('0, '1);
    send_block('1);
    send_block(128'h0123456789abcdef0123456789abcdef);
    drain();
  endtask

  // Back-to-back blocks under a random key with no idling at all.
  task automatic test_full_rate();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    load_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
    repeat (200) send_block(rand_block());
    drain();
  endtask

  // Random blocks under a series of keys, with random gaps on both sides.
  task automatic test_random_keys();
    src_idle_pct = 25;
    sink_stall_pct = 25;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: load_key('0, '0);
        1: load_key('1, '1);
        default: load_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
      endcase
      repeat (100) send_block(rand_block());
      drain();
    end
  endtask

  initial begin
    in_blk.valid = 1'b0;
    in_blk.data_high = '0;
    in_blk.data_low = '0;
    out_blk.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = aes_pkg::RegKeyHigh;
    cfg.wdata = '0;
    key_hi_shadow = '0;
    key_lo_shadow = '0;
    error_count = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    cycle_count = 0;
    key_writes = 0;
    src_idle_pct = 25;
    sink_stall_pct = 25;
    build_subst_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_rate();
    test_random_keys();

    $display("Encrypted %0d blocks, checked %0d ciphertexts, across %0d key writes.",
             blocks_sent, blocks_checked, key_writes);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
